// File: rtl/core/plts_pkg.sv
// ----------------------------------------------------------------------------
// plts_pkg: shared types for the preemptive LIFO task scheduler
// Holds the payload structs of both channels, the stack entry and control
// structs, the status codes and the sequencer state encoding.
// ----------------------------------------------------------------------------
package plts_pkg;

	// Input payload: one arriving task
	typedef struct packed {
		logic [7:0]  task_id;
		logic [10:0] start_minute;
		logic [9:0]  duration;
		logic        last_task;
	} task_t;

	// Output payload: one completed or dropped task
	typedef struct packed {
		logic [7:0] done_id;
		logic       status;
		logic       end_of_run;
	} result_t;

	// One paused task on the stack
	typedef struct packed {
		logic [7:0] id;
		logic [9:0] remaining;
	} entry_t;

	// Stack commands from the sequencer
	typedef struct packed {
		logic   push;
		logic   pop;
		logic   upd;
		entry_t ent;
	} stk_ctl_t;

	// Stack status back to the sequencer
	typedef struct packed {
		logic   full;
		logic   empty;
		entry_t top;
	} stk_sts_t;

	localparam logic STATUS_DONE     = 1'b0;
	localparam logic STATUS_OVERFLOW = 1'b1;

	// Sequencer states, one-hot
	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_GAP   = 7'b0000010,
		ST_CUR   = 7'b0000100,
		ST_POP   = 7'b0001000,
		ST_LOAD  = 7'b0010000,
		ST_FLUSH = 7'b0100000,
		ST_FIN   = 7'b1000000
	} state_t;

endpackage

// File: rtl/core/preemptive_lifo_task_scheduler.sv
// ----------------------------------------------------------------------------
// preemptive_lifo_task_scheduler: run-to-gap scheduler with a LIFO of
// paused tasks
//
// Tasks arrive on the task channel (task_valid / task_ready / task_data) in
// non-decreasing start order. The time since the previous start runs the
// current task; a finished task is reported and the remaining time resumes
// paused tasks from the stack, newest first. An unfinished task is paused on
// the stack, or reported with overflow status when the stack is full.
// A task flagged last is reported at once, followed by every paused task.
// Results leave on the result channel (result_valid / result_ready /
// result_data); end_of_run marks the final result of each task transfer.
//
// One task at a time: task_ready is high only while the sequencer is idle.
// A task steps through the gap, the current task if any, resumed pops, the
// load, any flush pops and the final step; stack pops go one at a time, as
// set by the single read port of the stack memory and the shared
// subtractor.
// Results trail the sequencer by one pending register and one output
// register. A stalled receiver holds the sequencer at its next result.
// Reset empties the stack and clears the current task and previous start.
// ----------------------------------------------------------------------------
module preemptive_lifo_task_scheduler #(
	parameter int STACK_DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              task_valid,
	output logic              task_ready,
	input  plts_pkg::task_t   task_data,
	output logic              result_valid,
	input  logic              result_ready,
	output plts_pkg::result_t result_data
);

	plts_pkg::state_t   state_q;
	plts_pkg::state_t   state_d;
	plts_pkg::task_t    in_q;
	plts_pkg::stk_ctl_t ctl;
	plts_pkg::stk_sts_t sts;
	plts_pkg::result_t  pend_q;
	plts_pkg::result_t  out_q;

	logic        have_cur_q;
	logic [7:0]  cur_id_q;
	logic [9:0]  cur_rem_q;
	logic [10:0] prev_q;
	logic [10:0] gap_q;
	logic [10:0] gap_d;
	logic        gap_we;
	logic        pend_valid_q;
	logic        out_valid_q;

	logic [10:0] sub_a;
	logic [10:0] sub_b;
	logic [11:0] sub_d;
	logic [11:0] sub_neg;
	logic        borrow;

	logic        ok;
	logic        gen;
	logic [7:0]  gen_id;
	logic        gen_st;
	logic        cur_load;
	logic        fin_push;
	logic        out_load;

	plts_stack #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ctl),
		.sts   (sts)
	);

	// Shared subtractor: operands chosen by the sequencer state
	always_comb begin
		case (state_q)
			plts_pkg::ST_GAP: begin
				sub_a = in_q.start_minute;
				sub_b = prev_q;
			end
			plts_pkg::ST_CUR: begin
				sub_a = gap_q;
				sub_b = {1'b0, cur_rem_q};
			end
			plts_pkg::ST_POP: begin
				sub_a = gap_q;
				sub_b = {1'b0, sts.top.remaining};
			end
			default: begin
				sub_a = '0;
				sub_b = '0;
			end
		endcase
	end

	assign sub_d   = {1'b0, sub_a} - {1'b0, sub_b};
	assign sub_neg = 12'd0 - sub_d;
	assign borrow  = sub_d[11];

	// A new result may move the pending one into the output register
	assign ok = !pend_valid_q || !out_valid_q || result_ready;

	// Sequencer
	always_comb begin
		state_d  = state_q;
		gen      = 1'b0;
		gen_id   = cur_id_q;
		gen_st   = plts_pkg::STATUS_DONE;
		ctl      = '0;
		gap_we   = 1'b0;
		gap_d    = gap_q;
		cur_load = 1'b0;
		fin_push = 1'b0;
		case (state_q)
			plts_pkg::ST_IDLE: begin
				if (task_valid) begin
					state_d = plts_pkg::ST_GAP;
				end
			end
			plts_pkg::ST_GAP: begin
				// Elapsed time, clamped at zero
				gap_we  = 1'b1;
				gap_d   = borrow ? '0 : sub_d[10:0];
				state_d = have_cur_q ? plts_pkg::ST_CUR : plts_pkg::ST_LOAD;
			end
			plts_pkg::ST_CUR: begin
				if (ok) begin
					if (!borrow) begin
						// Current task finishes, keep the leftover time
						gen     = 1'b1;
						gap_we  = 1'b1;
						gap_d   = sub_d[10:0];
						state_d = plts_pkg::ST_POP;
					end else begin
						// Pause the current task, or drop it when full
						if (!sts.full) begin
							ctl.push          = 1'b1;
							ctl.ent.id        = cur_id_q;
							ctl.ent.remaining = sub_neg[9:0];
						end else begin
							gen    = 1'b1;
							gen_st = plts_pkg::STATUS_OVERFLOW;
						end
						state_d = plts_pkg::ST_LOAD;
					end
				end
			end
			plts_pkg::ST_POP: begin
				if ((gap_q == '0) || sts.empty) begin
					state_d = plts_pkg::ST_LOAD;
				end else if (ok) begin
					if (borrow) begin
						// Top task only partly served: write back its time
						ctl.upd           = 1'b1;
						ctl.ent.id        = sts.top.id;
						ctl.ent.remaining = sub_neg[9:0];
						state_d           = plts_pkg::ST_LOAD;
					end else begin
						gen     = 1'b1;
						gen_id  = sts.top.id;
						gap_we  = 1'b1;
						gap_d   = sub_d[10:0];
						ctl.pop = 1'b1;
					end
				end
			end
			plts_pkg::ST_LOAD: begin
				if (ok) begin
					cur_load = 1'b1;
					if (in_q.last_task) begin
						gen     = 1'b1;
						gen_id  = in_q.task_id;
						state_d = plts_pkg::ST_FLUSH;
					end else begin
						state_d = plts_pkg::ST_FIN;
					end
				end
			end
			plts_pkg::ST_FLUSH: begin
				if (sts.empty) begin
					state_d = plts_pkg::ST_FIN;
				end else if (ok) begin
					gen     = 1'b1;
					gen_id  = sts.top.id;
					ctl.pop = 1'b1;
				end
			end
			plts_pkg::ST_FIN: begin
				// Release the pending result as the end of the run
				if (!pend_valid_q) begin
					state_d = plts_pkg::ST_IDLE;
				end else if (!out_valid_q || result_ready) begin
					fin_push = 1'b1;
					state_d  = plts_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = plts_pkg::ST_IDLE;
			end
		endcase
	end

	assign out_load = (gen && pend_valid_q) || fin_push;

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= plts_pkg::ST_IDLE;
			have_cur_q   <= 1'b0;
			cur_id_q     <= '0;
			cur_rem_q    <= '0;
			prev_q       <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == plts_pkg::ST_GAP) begin
				prev_q <= in_q.start_minute;
			end
			if (cur_load) begin
				cur_id_q <= in_q.task_id;
				if (in_q.last_task) begin
					have_cur_q <= 1'b0;
					cur_rem_q  <= '0;
				end else begin
					have_cur_q <= 1'b1;
					cur_rem_q  <= in_q.duration;
				end
			end
			if (gen) begin
				pend_valid_q <= 1'b1;
			end else if (fin_push) begin
				pend_valid_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (task_valid && task_ready) begin
			in_q <= task_data;
		end
		if (gap_we) begin
			gap_q <= gap_d;
		end
		if (gen) begin
			pend_q <= '{done_id: gen_id, status: gen_st, end_of_run: 1'b0};
		end
		if (out_load) begin
			out_q <= '{done_id: pend_q.done_id, status: pend_q.status, end_of_run: fin_push};
		end
	end

	assign task_ready   = (state_q == plts_pkg::ST_IDLE);
	assign result_valid = out_valid_q;
	assign result_data  = out_q;

	// Nothing is left pending while waiting for a task
	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == plts_pkg::ST_IDLE) |-> !pend_valid_q)
		else $error("result pending while idle");

	// A transfer on the task channel starts the gap step
	a_accept_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(task_valid && task_ready) |=> (state_q == plts_pkg::ST_GAP))
		else $error("accepted task did not start");

	// A last task leaves no current task and an empty stack
	a_last_flush: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == plts_pkg::ST_FIN) && in_q.last_task) |-> (!have_cur_q && sts.empty))
		else $error("state left after last task");

	// The output register is loaded only when free or draining
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || result_ready))
		else $error("output register overwritten");

endmodule

// File: rtl/core/plts_stack.sv
// ----------------------------------------------------------------------------
// plts_stack: LIFO of paused tasks
// Memory of paused entries with a count. The registered read port always
// presents the entry at the top of the stack, with write-to-read bypass.
// ----------------------------------------------------------------------------
module plts_stack #(
	parameter int STACK_DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  plts_pkg::stk_ctl_t ctl,
	output plts_pkg::stk_sts_t sts
);

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);

	plts_pkg::entry_t mem [STACK_DEPTH];
	plts_pkg::entry_t rd_q;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    count_d;
	logic [CW-1:0]    top_cnt;
	logic [CW-1:0]    rd_cnt;
	logic [AW-1:0]    wr_addr;
	logic [AW-1:0]    rd_addr;
	logic             we;

	// Advance the fill count
	always_comb begin
		count_d = count_q;
		if (ctl.push) begin
			count_d = count_q + CW'(1);
		end else if (ctl.pop) begin
			count_d = count_q - CW'(1);
		end
	end

	// Push writes above the top, update rewrites the top; read the next top
	assign top_cnt = count_q - CW'(1);
	assign rd_cnt  = count_d - CW'(1);
	assign wr_addr = ctl.push ? count_q[AW-1:0] : top_cnt[AW-1:0];
	assign rd_addr = rd_cnt[AW-1:0];
	assign we      = ctl.push | ctl.upd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	// Entry store with registered top read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= ctl.ent;
		end
		if (we && (wr_addr == rd_addr)) begin
			rd_q <= ctl.ent;
		end else begin
			rd_q <= mem[rd_addr];
		end
	end

	assign sts.full  = (count_q == CW'(STACK_DEPTH));
	assign sts.empty = (count_q == '0);
	assign sts.top   = rd_q;

	// Never push onto a full stack
	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.push |-> !sts.full)
		else $error("push onto full stack");

	// Never pop or update an empty stack
	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.pop || ctl.upd) |-> !sts.empty)
		else $error("pop or update on empty stack");

	// Commands are exclusive
	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.push, ctl.pop, ctl.upd}))
		else $error("conflicting stack commands");

endmodule
